/* rtl/ufj_pkg.sv */
// Shared constants for the union-find join engine.
package ufj_pkg;

    localparam int IN_W       = 11;      // width of the node number fields
    localparam int ROOT_OUT_W = 11;      // width of the reported root
    localparam int RANK_W     = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

endpackage

/* rtl/union_find_join_engine.sv */
// Each join finds both roots by following parent links, rewrites every entry on a
//   compressed path, links the roots and updates the rank when the ranks are equal.
//   Only one join is in flight at a time.
// Parent and rank share one RAM word per node; every read goes through its single
//   read port, so path length sets the cycle count.
// Reset: a clearing pass rewrites every entry (self parent, rank zero)
//   with s_ready low; the result register is emptied at once.
module union_find_join_engine
    import ufj_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_W-1:0]       s_node_a,
    input  logic [IN_W-1:0]       s_node_b,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_merged,
    output logic [ROOT_OUT_W-1:0] m_root_out
);

    localparam int AW = $clog2(NODES);
    localparam int IW = (AW > IN_W) ? AW : IN_W;
    localparam int RW = (AW + 1 > ROOT_OUT_W) ? AW + 1 : ROOT_OUT_W;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [AW-1:0]     parent;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND,
        ST_COMP_RD,
        ST_COMP,
        ST_LINK,
        ST_RANK,
        ST_RESP
    } state_t;

    function automatic logic [AW-1:0] to_idx(input logic [IN_W-1:0] n);
        logic [IW-1:0] t;
        t = IW'(n) - IW'(1);
        return t[AW-1:0];
    endfunction

    function automatic logic [ROOT_OUT_W-1:0] to_out(input logic [AW-1:0] r);
        logic [RW-1:0] t;
        t = RW'(r) + RW'(1);
        return t[ROOT_OUT_W-1:0];
    endfunction

    function automatic logic in_range(input logic [IN_W-1:0] n);
        return (n != '0) && (int'(n) <= NODES);
    endfunction

    state_t                state_reg, state_next;
    logic                  side_reg, side_next;       // 0: walking node a, 1: node b
    logic [AW-1:0]         clr_reg, clr_next;
    logic [AW-1:0]         a_idx_reg, a_idx_next;
    logic [AW-1:0]         b_idx_reg, b_idx_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic [AW-1:0]         ra_reg, ra_next;
    logic [AW-1:0]         rb_reg, rb_next;
    logic [RANK_W-1:0]     ra_rank_reg, ra_rank_next;
    logic [RANK_W-1:0]     rb_rank_reg, rb_rank_next;
    logic                  res_merged_reg, res_merged_next;
    logic [ROOT_OUT_W-1:0] res_out_reg, res_out_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_merged_reg, m_merged_next;
    logic [ROOT_OUT_W-1:0] m_root_reg, m_root_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    logic [AW-1:0] start_idx;
    logic [AW-1:0] root_sel;

    ufj_ram #(
        .WIDTH (EW),
        .DEPTH (NODES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign start_idx = side_reg ? b_idx_reg : a_idx_reg;
    assign root_sel  = side_reg ? rb_reg : ra_reg;

    always_comb begin
        state_next      = state_reg;
        side_next       = side_reg;
        clr_next        = clr_reg;
        a_idx_next      = a_idx_reg;
        b_idx_next      = b_idx_reg;
        cur_next        = cur_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        ra_rank_next    = ra_rank_reg;
        rb_rank_next    = rb_rank_reg;
        res_merged_next = res_merged_reg;
        res_out_next    = res_out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_merged_next   = m_merged_reg;
        m_root_next     = m_root_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = cur_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '{rank: '0, parent: clr_reg};
                if (clr_reg == AW'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    a_idx_next = to_idx(s_node_a);
                    b_idx_next = to_idx(s_node_b);
                    cur_next   = to_idx(s_node_a);
                    side_next  = 1'b0;
                    if (in_range(s_node_a) && in_range(s_node_b)) begin
                        state_next = ST_FIND_RD;
                    end else begin
                        res_merged_next = 1'b0;
                        res_out_next    = '0;
                        state_next      = ST_RESP;
                    end
                end
            end
            ST_FIND_RD: begin
                rd_en      = 1'b1;
                rd_addr    = cur_reg;
                state_next = ST_FIND;
            end
            ST_FIND: begin
                if (rd_data.parent == cur_reg) begin
                    if (side_reg) begin
                        rb_next      = cur_reg;
                        rb_rank_next = rd_data.rank;
                    end else begin
                        ra_next      = cur_reg;
                        ra_rank_next = rd_data.rank;
                    end
                    cur_next = start_idx;
                    if (start_idx != cur_reg) begin
                        state_next = ST_COMP_RD;
                    end else if (side_reg) begin
                        state_next = ST_LINK;
                    end else begin
                        side_next  = 1'b1;
                        cur_next   = b_idx_reg;
                        state_next = ST_FIND_RD;
                    end
                end else begin
                    // follow the link; the next read goes out right away
                    cur_next = rd_data.parent;
                    rd_en    = 1'b1;
                    rd_addr  = rd_data.parent;
                end
            end
            ST_COMP_RD: begin
                rd_en      = 1'b1;
                rd_addr    = cur_reg;
                state_next = ST_COMP;
            end
            ST_COMP: begin
                // point this entry at the root, read the old parent in the same cycle
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = '{rank: rd_data.rank, parent: root_sel};
                if (rd_data.parent == root_sel) begin
                    if (side_reg) begin
                        state_next = ST_LINK;
                    end else begin
                        side_next  = 1'b1;
                        cur_next   = b_idx_reg;
                        state_next = ST_FIND_RD;
                    end
                end else begin
                    cur_next = rd_data.parent;
                    rd_en    = 1'b1;
                    rd_addr  = rd_data.parent;
                end
            end
            ST_LINK: begin
                priority if (ra_reg == rb_reg) begin
                    res_merged_next = 1'b0;
                    res_out_next    = to_out(ra_reg);
                    state_next      = ST_RESP;
                end else if (ra_rank_reg == rb_rank_reg) begin
                    wr_en           = 1'b1;
                    wr_addr         = rb_reg;
                    wr_data         = '{rank: rb_rank_reg, parent: ra_reg};
                    res_merged_next = 1'b1;
                    res_out_next    = to_out(ra_reg);
                    state_next      = ST_RANK;
                end else if (ra_rank_reg > rb_rank_reg) begin
                    wr_en           = 1'b1;
                    wr_addr         = rb_reg;
                    wr_data         = '{rank: rb_rank_reg, parent: ra_reg};
                    res_merged_next = 1'b1;
                    res_out_next    = to_out(ra_reg);
                    state_next      = ST_RESP;
                end else begin
                    wr_en           = 1'b1;
                    wr_addr         = ra_reg;
                    wr_data         = '{rank: ra_rank_reg, parent: rb_reg};
                    res_merged_next = 1'b1;
                    res_out_next    = to_out(rb_reg);
                    state_next      = ST_RESP;
                end
            end
            ST_RANK: begin
                // rank saturates at its maximum
                wr_en      = 1'b1;
                wr_addr    = ra_reg;
                wr_data    = '{rank: (ra_rank_reg == RANK_MAX) ? RANK_MAX
                                                         : ra_rank_reg + RANK_W'(1),
                               parent: ra_reg};
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_merged_next = res_merged_reg;
                    m_root_next   = res_out_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            side_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            side_reg    <= side_next;
            m_valid_reg <= m_valid_next;
        end
        a_idx_reg      <= a_idx_next;
        b_idx_reg      <= b_idx_next;
        cur_reg        <= cur_next;
        ra_reg         <= ra_next;
        rb_reg         <= rb_next;
        ra_rank_reg    <= ra_rank_next;
        rb_rank_reg    <= rb_rank_next;
        res_merged_reg <= res_merged_next;
        res_out_reg    <= res_out_next;
        m_merged_reg   <= m_merged_next;
        m_root_reg     <= m_root_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_merged   = m_merged_reg;
    assign m_root_out = m_root_reg;

endmodule

/* rtl/ufj_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ufj_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/ufj_checker.sv */
// Port-level assertions for the union-find join engine, bound to the top level.
module ufj_checker
    import ufj_pkg::*;
#(
    parameter int NODES = 1024
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_merged,
    input logic [ROOT_OUT_W-1:0] m_root_out
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one join in flight: no new transaction right after one is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a join is in progress");

    // a merge always names a real root
    a_merge_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (NODES < 2048) && m_valid && m_merged |->
            (m_root_out != '0) && (int'(m_root_out) <= NODES))
        else $error("merge reported with an invalid root");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_merged) && $stable(m_root_out))
        else $error("stalled result changed");

endmodule

bind union_find_join_engine ufj_checker #(.NODES(NODES)) u_ufj_checker (.*);

/* tb/tb.sv */
// Testbench for union_find_join_engine: random and directed joins checked against a local model.
`timescale 1ns / 1ps

module tb;
    import ufj_pkg::*;

    localparam int NODES       = 1024;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic                  merged;
        logic [ROOT_OUT_W-1:0] root;
    } join_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_W-1:0]       s_node_a;
    logic [IN_W-1:0]       s_node_b;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_merged;
    logic [ROOT_OUT_W-1:0] m_root_out;

    // Local copy of the disjoint-set state, indexed from one
    int unsigned       parent_of [1:NODES];
    logic [RANK_W-1:0] rank_of   [1:NODES];

    join_result_t join_results[$];
    int           fail_count  = 0;
    int           valid_sent;
    int           cycle_count = 0;
    int           stall_left  = 0;
    logic         quiet;

    union_find_join_engine #(.NODES(NODES)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_node_a  (s_node_a),
        .s_node_b  (s_node_b),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_merged  (m_merged),
        .m_root_out(m_root_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Walk to the root, then point every entry on the path straight at it
    function automatic int unsigned find_and_flatten(int unsigned x);
        int unsigned root;
        int unsigned nxt;
        root = x;
        while (parent_of[root] != root)
            root = parent_of[root];
        while (x != root) begin
            nxt = parent_of[x];
            parent_of[x] = root;
            x = nxt;
        end
        return root;
    endfunction

    function automatic join_result_t predict_join(logic [IN_W-1:0] a, logic [IN_W-1:0] b);
        join_result_t r;
        int unsigned  ra;
        int unsigned  rb;
        int unsigned  survivor;
        r.merged = 1'b0;
        r.root   = '0;
        if (a < 1 || a > NODES || b < 1 || b > NODES)
            return r;
        ra = find_and_flatten(32'(a));
        rb = find_and_flatten(32'(b));
        if (ra == rb) begin
            r.root = ra[ROOT_OUT_W-1:0];
            return r;
        end
        if (rank_of[ra] == rank_of[rb]) begin
            if (rank_of[ra] < RANK_MAX)
                rank_of[ra] = rank_of[ra] + RANK_W'(1);
            parent_of[rb] = ra;
            survivor = ra;
        end else if (rank_of[ra] > rank_of[rb]) begin
            parent_of[rb] = ra;
            survivor = ra;
        end else begin
            parent_of[ra] = rb;
            survivor = rb;
        end
        r.merged = 1'b1;
        r.root   = survivor[ROOT_OUT_W-1:0];
        return r;
    endfunction

    // Sender idles only in some stretches of the run
    function automatic logic src_idle_zone();
        return ((valid_sent / 50) % 4) != 3;
    endfunction

    task automatic send_join(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
        int gap;
        if (!quiet && src_idle_zone() && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_node_a <= a;
        s_node_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        join_results.insert(join_results.size(), predict_join(a, b));
        if (a >= 1 && a <= NODES && b >= 1 && b <= NODES)
            valid_sent++;
    endtask

    function automatic logic [IN_W-1:0] bad_node();
        if ($urandom_range(0, 1) == 0)
            return '0;
        return IN_W'($urandom_range(NODES + 1, (1 << IN_W) - 1));
    endfunction

    function automatic logic [IN_W-1:0] pick_node(int base, int size);
        return IN_W'(base + $urandom_range(0, size - 1));
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_join(bad_node(), IN_W'($urandom_range(1, NODES)));
            1: send_join(IN_W'($urandom_range(1, NODES)), bad_node());
            default: send_join(bad_node(), bad_node());
        endcase
    endtask

    task automatic test_rank_linking();
        send_join(1, 1);          // same element twice
        send_join(1, 2);          // equal rank, first root wins
        send_join(3, 1);          // lower rank hangs under higher
        send_join(1, 4);
        send_join(2, 4);          // already joined
        send_join(5, 6);
        send_join(7, 8);
        send_join(5, 7);
        send_join(8, 2);          // path walk plus compression
        send_join(6, 3);
        send_join(1024, 1023);
        send_join(1, 1024);
        send_join(10, 9);
        send_join(12, 11);
        send_join(11, 9);
        send_join(12, 5);
    endtask

    task automatic test_bad_nodes();
        send_join(0, 5);
        send_join(5, 0);
        send_join(0, 0);
        send_join(1025, 1);
        send_join(1, 2047);
        send_join(2047, 2047);
        send_join(1024, 1024);
        send_join(1024, 1);
    endtask

    // Pairwise doubling inside a window gives deep trees; members picked at random
    task automatic test_tree_building(input int target);
        int k;
        int size;
        int base;
        int step;
        int i;
        logic [IN_W-1:0] x;
        logic [IN_W-1:0] y;
        while (valid_sent < target) begin
            k    = $urandom_range(2, 6);
            size = 1 << k;
            base = $urandom_range(1, NODES - size + 1);
            for (step = 1; step < size; step = step * 2) begin
                for (i = 0; i < size; i = i + 2 * step) begin
                    x = pick_node(base + i, step);
                    y = pick_node(base + i + step, step);
                    if ($urandom_range(0, 1) == 1)
                        send_join(y, x);
                    else
                        send_join(x, y);
                end
            end
            repeat (4) send_join(pick_node(base, size), pick_node(base, size));
            if ($urandom_range(0, 7) == 0)
                send_noise();
        end
    endtask

    task automatic test_random_joins(input int target);
        int size;
        int base;
        int len;
        while (valid_sent < target) begin
            case ($urandom_range(0, 9))
                0: send_noise();
                9: send_join(pick_node(1, NODES), pick_node(1, NODES));
                default: begin
                    size = $urandom_range(4, 128);
                    base = $urandom_range(1, NODES - size + 1);
                    len  = $urandom_range(4, 20);
                    repeat (len) send_join(pick_node(base, size), pick_node(base, size));
                end
            endcase
        end
    endtask

    task automatic test_back_to_back(input int target);
        quiet = 1'b1;
        test_random_joins(target);
    endtask

    // Result sink with bursty stalls
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && cycle_count[9:8] != 2'b11 && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        join_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (join_results.size() == 0) begin
                $error("result transaction with nothing expected: merged=%0d root_out=%0d",
                       m_merged, m_root_out);
                fail_count++;
            end else begin
                want = join_results.pop_front();
                if (m_merged !== want.merged) begin
                    $error("merged: expected %0d, got %0d", want.merged, m_merged);
                    fail_count++;
                end
                if (m_root_out !== want.root) begin
                    $error("root_out: expected %0d, got %0d", want.root, m_root_out);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int i;
        valid_sent  = 0;
        quiet       = 1'b0;
        for (i = 1; i <= NODES; i++) begin
            parent_of[i] = i;
            rank_of[i]   = '0;
        end
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_node_a <= '0;
        s_node_b <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_rank_linking();
        test_bad_nodes();
        test_tree_building(260);
        test_random_joins(850);
        test_back_to_back(950);

        s_valid <= 1'b0;
        while (join_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
